@@ rtl/core/i2cmts_pkg.sv @@
package i2cmts_pkg;

  // command opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // classified bus events
  localparam logic [3:0] EV_START      = 4'd0;
  localparam logic [3:0] EV_RESTART    = 4'd1;
  localparam logic [3:0] EV_ADDRW_ACK  = 4'd2;
  localparam logic [3:0] EV_DATAW_ACK  = 4'd3;
  localparam logic [3:0] EV_DATAR_ACK  = 4'd4;
  localparam logic [3:0] EV_ADDRR_ACK  = 4'd5;
  localparam logic [3:0] EV_DATAR_NACK = 4'd6;
  localparam logic [3:0] EV_ARB_LOST   = 4'd7;

  // command word
  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] buffer_index;
    logic [7:0] write_byte;
    logic [7:0] transfer_length;
    logic [3:0] event_kind;
    logic [7:0] rx_byte;
    logic [7:0] status_byte;
  } cmd_word_t;

  // response word
  typedef struct packed {
    logic       set_start;
    logic       set_stop;
    logic       set_ack;
    logic       keep_irq;
    logic       clear_flag;
    logic [7:0] send_byte;
    logic       send_valid;
    logic [7:0] read_byte;
    logic       transfer_ok;
    logic       error_flag;
    logic [7:0] error_status;
  } rsp_word_t;

  // buffer access, at most one per accepted command
  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;

  // response fields resolved before the buffer read returns
  typedef struct packed {
    logic       set_start;
    logic       set_stop;
    logic       set_ack;
    logic       keep_irq;
    logic       clear_flag;
    logic       send_valid;
    logic       read_sel;
    logic       transfer_ok;
    logic       error_flag;
    logic [7:0] error_status;
  } stage_t;

endpackage

@@ rtl/core/i2c_master_transfer_sequencer.sv @@
// Transfer sequencer of an I2C master: takes buffer loads, transfer starts,
// classified bus status events and buffer reads, one command word per cycle
// unless stalled, and answers each with one response word from the output
// register. The byte buffer is a single-port memory with a registered read,
// and each command makes at most one access to it, so words can follow back
// to back; a word whose response cannot leave waits in the read stage while
// the response ahead of it sits in the output register. Buffer contents are
// not cleared at reset, so an entry must be loaded before it is read or sent.
module i2c_master_transfer_sequencer #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  i2cmts_pkg::cmd_word_t cmd,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output i2cmts_pkg::rsp_word_t rsp
);
  import i2cmts_pkg::*;

  logic     accept;
  mem_req_t req;
  stage_t   stage_next;
  logic [7:0] rdata;

  assign accept = cmd_valid && !cmd_stall;

  // decode and pointer state
  i2cmts_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .req       (req),
    .stage_next(stage_next)
  );

  // byte buffer
  i2cmts_buffer #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_buffer (
    .clk  (clk),
    .req  (req),
    .rdata(rdata)
  );

  // read stage and output register
  i2cmts_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .stage_next(stage_next),
    .rdata     (rdata),
    .busy      (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

@@ rtl/core/i2cmts_buffer.sv @@
module i2cmts_buffer #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                clk,
  input  i2cmts_pkg::mem_req_t req,
  output logic [7:0]          rdata
);
  import i2cmts_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [7:0] mem [BUFFER_DEPTH];

  // single port buffer, registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

@@ rtl/core/i2cmts_ctrl.sv @@
module i2cmts_ctrl #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  i2cmts_pkg::cmd_word_t cmd,
  output i2cmts_pkg::mem_req_t  req,
  output i2cmts_pkg::stage_t    stage_next
);
  import i2cmts_pkg::*;

  localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

  logic [7:0] byte_pointer, byte_pointer_next;
  logic [7:0] active_length, active_length_next;
  logic       done_ok, done_ok_next;
  logic [7:0] last_error, last_error_next;

  logic [7:0] ptr_eff;
  logic [7:0] ptr_inc;
  logic       ptr_in_range;
  logic       idx_in_range;
  logic       we, re;
  logic [7:0] addr, wdata;
  stage_t     st;

  assign ptr_inc      = byte_pointer + 8'd1;
  assign ptr_in_range = {1'b0, byte_pointer} < DEPTH9;
  assign idx_in_range = {2'b00, cmd.buffer_index} < DEPTH9;
  // start and restart rewind the pointer before the send check
  assign ptr_eff      = (cmd.event_kind == EV_START || cmd.event_kind == EV_RESTART) ?
                        8'd0 : byte_pointer;

  // command decode and scalar state update
  always_comb begin
    byte_pointer_next  = byte_pointer;
    active_length_next = active_length;
    done_ok_next       = done_ok;
    last_error_next    = last_error;
    we    = 1'b0;
    re    = 1'b0;
    addr  = 8'd0;
    wdata = cmd.rx_byte;
    st    = '0;
    case (cmd.opcode)
      OP_LOAD: begin
        we    = idx_in_range;
        addr  = {1'b0, cmd.buffer_index};
        wdata = cmd.write_byte;
      end
      OP_START: begin
        active_length_next = ({1'b0, cmd.transfer_length} > DEPTH9) ?
                             DEPTH9[7:0] : cmd.transfer_length;
        done_ok_next = 1'b0;
        st.set_start  = 1'b1;
        st.keep_irq   = 1'b1;
        st.clear_flag = 1'b1;
      end
      OP_READ: begin
        re          = idx_in_range;
        addr        = {1'b0, cmd.buffer_index};
        st.read_sel = idx_in_range;
      end
      default: begin
        case (cmd.event_kind)
          EV_START, EV_RESTART, EV_ADDRW_ACK, EV_DATAW_ACK: begin
            byte_pointer_next = ptr_eff;
            st.clear_flag     = 1'b1;
            if (ptr_eff < active_length) begin
              re                = 1'b1;
              addr              = ptr_eff;
              byte_pointer_next = ptr_eff + 8'd1;
              st.send_valid     = 1'b1;
              st.keep_irq       = 1'b1;
            end else begin
              done_ok_next = 1'b1;
              st.set_stop  = 1'b1;
            end
          end
          EV_DATAR_ACK: begin
            we                = ptr_in_range;
            addr              = byte_pointer;
            byte_pointer_next = ptr_inc;
            st.set_ack    = ({1'b0, ptr_inc} + 9'd1) < {1'b0, active_length};
            st.keep_irq   = 1'b1;
            st.clear_flag = 1'b1;
          end
          EV_ADDRR_ACK: begin
            st.set_ack    = ({1'b0, byte_pointer} + 9'd1) < {1'b0, active_length};
            st.keep_irq   = 1'b1;
            st.clear_flag = 1'b1;
          end
          EV_DATAR_NACK: begin
            we            = ptr_in_range;
            addr          = byte_pointer;
            done_ok_next  = 1'b1;
            st.set_stop   = 1'b1;
            st.clear_flag = 1'b1;
          end
          EV_ARB_LOST: begin
            st.set_start  = 1'b1;
            st.keep_irq   = 1'b1;
            st.clear_flag = 1'b1;
          end
          default: begin
            last_error_next = cmd.status_byte;
            st.error_flag   = 1'b1;
          end
        endcase
      end
    endcase
    st.transfer_ok  = done_ok_next;
    st.error_status = last_error_next;
  end

  // buffer access only for accepted words
  assign req.we    = we & accept;
  assign req.re    = re & accept;
  assign req.addr  = addr;
  assign req.wdata = wdata;
  assign stage_next = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pointer  <= 8'd0;
      active_length <= 8'd0;
      done_ok       <= 1'b0;
      last_error    <= 8'd0;
    end else if (accept) begin
      byte_pointer  <= byte_pointer_next;
      active_length <= active_length_next;
      done_ok       <= done_ok_next;
      last_error    <= last_error_next;
    end
  end

endmodule

@@ rtl/core/i2cmts_out_stage.sv @@
module i2cmts_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  i2cmts_pkg::stage_t    stage_next,
  input  logic [7:0]            rdata,
  output logic                  busy,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output i2cmts_pkg::rsp_word_t rsp
);
  import i2cmts_pkg::*;

  logic      s1_valid;
  stage_t    s1;
  logic      advance;
  rsp_word_t rsp_next;

  // the read stage moves on whenever the output register is free or draining
  assign advance = s1_valid && (!rsp_valid || !rsp_stall);
  assign busy    = s1_valid && rsp_valid && rsp_stall;

  // merge buffer read data into the response word
  always_comb begin
    rsp_next.set_start    = s1.set_start;
    rsp_next.set_stop     = s1.set_stop;
    rsp_next.set_ack      = s1.set_ack;
    rsp_next.keep_irq     = s1.keep_irq;
    rsp_next.clear_flag   = s1.clear_flag;
    rsp_next.send_byte    = s1.send_valid ? rdata : 8'd0;
    rsp_next.send_valid   = s1.send_valid;
    rsp_next.read_byte    = s1.read_sel ? rdata : 8'd0;
    rsp_next.transfer_ok  = s1.transfer_ok;
    rsp_next.error_flag   = s1.error_flag;
    rsp_next.error_status = s1.error_status;
  end

  // read stage and output register valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage_next;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule
